FILE: src/bat_pkg.sv
// Package for the breakpoint address table.
// Field widths, operation and status codes, used-bit word geometry. No dependencies.
package bat_pkg;

  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 2;
  localparam int HANDLE_W = 6;

  // used bits are kept in words of this size
  localparam int USED_W  = 32;
  localparam int USED_BW = 5;

  // remainder unit retires one hex digit per step
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = ADDR_W / DIGIT_W;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

FILE: src/bat_in_if.sv
// Request channel of the breakpoint address table: valid/ready plus operation and address.
// Depends on bat_pkg.
interface bat_in_if;
  logic                         valid;
  logic                         ready;
  logic [bat_pkg::MODE_W-1:0]   mode;
  logic [bat_pkg::ADDR_W-1:0]   bp_address;

  modport source (output valid, output mode, output bp_address, input ready);
  modport sink   (input valid, input mode, input bp_address, output ready);
endinterface

FILE: src/bat_out_if.sv
// Result channel of the breakpoint address table: valid/ready plus status, hit flag, handle.
// Depends on bat_pkg.
interface bat_out_if;
  logic                           valid;
  logic                           ready;
  logic [bat_pkg::STATUS_W-1:0]   status;
  logic                           already_present;
  logic [bat_pkg::HANDLE_W-1:0]   entry_handle;

  modport source (output valid, output status, output already_present, output entry_handle,
                  input ready);
  modport sink   (input valid, input status, input already_present, input entry_handle,
                  output ready);
endinterface

FILE: src/bat_mod.sv
// Bucket index unit: 64-bit address modulo BUCKETS.
// Power-of-two counts take a mask; others a restoring remainder, one digit per cycle. Uses bat_pkg.
module bat_mod #(
  parameter int BUCKETS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bat_pkg::ADDR_W-1:0]   addr,
  output logic                         done,
  output logic [$clog2(BUCKETS)-1:0]   rem
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int TW    = BW + bat_pkg::DIGIT_W;
  localparam bit POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int CNTW  = $clog2(bat_pkg::DIGITS);
  localparam logic [TW-1:0] BQ = TW'(BUCKETS);
  localparam logic [CNTW-1:0] LAST = CNTW'(bat_pkg::DIGITS - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [bat_pkg::ADDR_W-1:0]  data_r;
  logic [BW-1:0]               rem_r;
  logic [CNTW-1:0]             cnt_r;
  logic [BW-1:0]               rem_step;

  // rem*16 + digit, then reduce by 8B, 4B, 2B, B
  always_comb begin
    logic [TW-1:0] t;
    t = {rem_r, data_r[bat_pkg::ADDR_W-1 -: bat_pkg::DIGIT_W]};
    for (int k = bat_pkg::DIGIT_W - 1; k >= 0; k--) begin
      if (t >= (BQ << k)) begin
        t = t - (BQ << k);
      end
    end
    rem_step = t[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (POW2) begin
          rem_r  <= addr[BW-1:0];
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          data_r <= addr;
          rem_r  <= '0;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        rem_r  <= rem_step;
        data_r <= data_r << bat_pkg::DIGIT_W;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: src/bat_used.sv
// Entry allocation bits, kept as 32-bit words in a memory, with a first-free encoder
// on the registered read word. Uses bat_pkg.
module bat_used #(
  parameter int ENTRIES = 64,
  localparam int UWORDS = (ENTRIES + bat_pkg::USED_W - 1) / bat_pkg::USED_W,
  localparam int UAW    = (UWORDS > 1) ? $clog2(UWORDS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [UAW-1:0]                       rd_word,
  input  logic                                 wr_en,
  input  logic [UAW-1:0]                       wr_word,
  input  logic [bat_pkg::USED_W-1:0]           wr_data,
  output logic [bat_pkg::USED_W-1:0]           rdata,
  output logic                                 free_any,
  output logic [bat_pkg::USED_BW-1:0]          free_bit
);

  logic [bat_pkg::USED_W-1:0] mem [UWORDS];
  logic [bat_pkg::USED_W-1:0] rdata_r;
  logic [UAW-1:0]             rword_r;
  logic [bat_pkg::USED_W-1:0] free_vec;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_word] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_word];
      rword_r <= rd_word;
    end
  end

  // bits past the last entry count as taken
  always_comb begin
    for (int j = 0; j < bat_pkg::USED_W; j++) begin
      free_vec[j] = !rdata_r[j] &&
                    ((int'(rword_r) * bat_pkg::USED_W + j) < ENTRIES);
    end
  end

  always_comb begin
    free_bit = '0;
    for (int j = bat_pkg::USED_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        free_bit = bat_pkg::USED_BW'(j);
      end
    end
  end

  assign free_any = |free_vec;
  assign rdata    = rdata_r;

endmodule

FILE: src/breakpoint_address_table.sv
// Breakpoint address table: chained hash of 64-bit addresses over a pool of ENTRIES.
// Depends on bat_pkg, bat_in_if, bat_out_if, bat_mod and bat_used.
//
// Usage: one request transfer on in_ch (mode insert/find/delete, bp_address) gives one
// result transfer on out_ch (status, already_present, entry_handle). One request is in
// flight at a time; in_ch.ready is high only while the sequencer is idle.
// Sequence from request transfer to result valid: the bucket index is formed (a mask for
//   power-of-two BUCKETS, the digit-serial remainder otherwise), the bucket head is read,
//   and chain entries are compared in turn; a new insert then scans up to ceil(ENTRIES/32)
//   used-bit words and links the free entry at the chain tail, and a successful delete
//   clears its used bit. The chain walk paces the block: one entry memory read
//   and one address compare per cycle.
// Reset: a clearing pass empties all bucket heads and used bits; no request is taken until it ends.
// Stall: the result sits in an output register; if out_ch.ready is low the sequencer
// holds its finished result and takes no new request until the register frees up.
module breakpoint_address_table #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bat_in_if.sink    in_ch,
  bat_out_if.source out_ch
);

  localparam int BW     = $clog2(BUCKETS);
  localparam int EW     = $clog2(ENTRIES);
  localparam int PW     = EW + 1;                 // pointer with room for "none"
  localparam int AW     = bat_pkg::ADDR_W;
  localparam int HW     = bat_pkg::HANDLE_W;
  localparam int SW     = bat_pkg::STATUS_W;
  localparam int UWORDS = (ENTRIES + bat_pkg::USED_W - 1) / bat_pkg::USED_W;
  localparam int UAW    = (UWORDS > 1) ? $clog2(UWORDS) : 1;
  localparam int IW     = UAW + bat_pkg::USED_BW; // index split into word/bit
  localparam int CLR    = (BUCKETS > UWORDS) ? BUCKETS : UWORDS;
  localparam int CW     = $clog2(CLR);

  localparam logic [PW-1:0]  NIL      = '1;
  localparam logic [PW-1:0]  PTR_LIM  = PW'(ENTRIES);
  localparam logic [UAW-1:0] LAST_WD  = UAW'(UWORDS - 1);
  localparam logic [CW-1:0]  CLR_LAST = CW'(CLR - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_FREE  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_LINK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // ---------------------------------------------------------------- registers
  logic [3:0]                 state_r,   state_nxt;
  logic [CW-1:0]              clr_r,     clr_nxt;
  logic [bat_pkg::MODE_W-1:0] mode_r,    mode_nxt;
  logic [AW-1:0]              baddr_r,   baddr_nxt;
  logic [BW-1:0]              bucket_r,  bucket_nxt;
  logic [EW-1:0]              cur_r,     cur_nxt;
  logic [PW-1:0]              prev_r,    prev_nxt;   // predecessor on hit, tail on miss
  logic [UAW-1:0]             word_r,    word_nxt;
  logic [EW-1:0]              fidx_r,    fidx_nxt;
  logic [SW-1:0]              rstat_r,   rstat_nxt;
  logic                       rpres_r,   rpres_nxt;
  logic [HW-1:0]              rhdl_r,    rhdl_nxt;
  logic                       ovalid_r,  ovalid_nxt;
  logic [SW-1:0]              ostat_r,   ostat_nxt;
  logic                       opres_r,   opres_nxt;
  logic [HW-1:0]              ohdl_r,    ohdl_nxt;

  // ---------------------------------------------------------------- memories
  logic [PW-1:0] head_mem [BUCKETS];
  logic [AW-1:0] eaddr_mem [ENTRIES];
  logic [PW-1:0] enext_mem [ENTRIES];

  logic [PW-1:0] head_q_r;
  logic [AW-1:0] eaddr_q_r;
  logic [PW-1:0] enext_q_r;

  logic          head_re,  head_we;
  logic [BW-1:0] head_raddr, head_waddr;
  logic [PW-1:0] head_wdata;
  logic          ent_re;
  logic [EW-1:0] ent_raddr;
  logic          eaddr_we;
  logic [EW-1:0] eaddr_waddr;
  logic          enext_we;
  logic [EW-1:0] enext_waddr;
  logic [PW-1:0] enext_wdata;

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_q_r <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (eaddr_we) begin
      eaddr_mem[eaddr_waddr] <= baddr_r;
    end
    if (enext_we) begin
      enext_mem[enext_waddr] <= enext_wdata;
    end
    if (ent_re) begin
      eaddr_q_r <= eaddr_mem[ent_raddr];
      enext_q_r <= enext_mem[ent_raddr];
    end
  end

  // ---------------------------------------------------------------- sub-units
  logic                          in_xfer;
  logic                          mod_done;
  logic [BW-1:0]                 mod_rem;

  logic                          used_re, used_we;
  logic [UAW-1:0]                used_rword, used_wword;
  logic [bat_pkg::USED_W-1:0]    used_wdata, used_rdata;
  logic                          used_free_any;
  logic [bat_pkg::USED_BW-1:0]   used_free_bit;

  assign in_xfer = in_ch.valid && in_ch.ready;

  bat_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .addr  (in_ch.bp_address),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  bat_used #(.ENTRIES(ENTRIES)) u_used (
    .clk      (clk),
    .rd_en    (used_re),
    .rd_word  (used_rword),
    .wr_en    (used_we),
    .wr_word  (used_wword),
    .wr_data  (used_wdata),
    .rdata    (used_rdata),
    .free_any (used_free_any),
    .free_bit (used_free_bit)
  );

  // word/bit split of the current entry, and the entry picked by the scan
  logic [IW-1:0] cur_ext;
  logic [IW-1:0] fnd_ext;
  logic          prev_none;

  assign cur_ext   = IW'(cur_r);
  assign fnd_ext   = {word_r, used_free_bit};
  assign prev_none = (prev_r >= PTR_LIM);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    logic go_miss;

    state_nxt  = state_r;
    clr_nxt    = clr_r;
    mode_nxt   = mode_r;
    baddr_nxt  = baddr_r;
    bucket_nxt = bucket_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    word_nxt   = word_r;
    fidx_nxt   = fidx_r;
    rstat_nxt  = rstat_r;
    rpres_nxt  = rpres_r;
    rhdl_nxt   = rhdl_r;

    head_re     = 1'b0;
    head_raddr  = bucket_r;
    head_we     = 1'b0;
    head_waddr  = bucket_r;
    head_wdata  = NIL;
    ent_re      = 1'b0;
    ent_raddr   = cur_r;
    eaddr_we    = 1'b0;
    eaddr_waddr = fidx_r;
    enext_we    = 1'b0;
    enext_waddr = prev_r[EW-1:0];
    enext_wdata = NIL;
    used_re     = 1'b0;
    used_rword  = word_r;
    used_we     = 1'b0;
    used_wword  = word_r;
    used_wdata  = used_rdata;
    go_miss     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // empty every bucket head and used word
        head_we    = (int'(clr_r) < BUCKETS);
        head_waddr = clr_r[BW-1:0];
        head_wdata = NIL;
        used_we    = (int'(clr_r) < UWORDS);
        used_wword = clr_r[UAW-1:0];
        used_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt  = in_ch.mode;
          baddr_nxt = in_ch.bp_address;
          state_nxt = S_MOD;
        end
      end

      S_MOD: begin
        if (mod_done) begin
          bucket_nxt = mod_rem;
          head_re    = 1'b1;
          head_raddr = mod_rem;
          state_nxt  = S_HEAD;
        end
      end

      S_HEAD: begin
        prev_nxt = NIL;
        if (head_q_r >= PTR_LIM) begin
          go_miss = 1'b1;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = head_q_r[EW-1:0];
          cur_nxt   = head_q_r[EW-1:0];
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        if (eaddr_q_r == baddr_r) begin
          rstat_nxt = bat_pkg::ST_OK;
          rpres_nxt = 1'b1;
          rhdl_nxt  = HW'(cur_r);
          if (mode_r == bat_pkg::MODE_DELETE) begin
            // unlink: predecessor (or bucket head) takes over our successor
            if (prev_none) begin
              head_we    = 1'b1;
              head_wdata = enext_q_r;
            end else begin
              enext_we    = 1'b1;
              enext_wdata = enext_q_r;
            end
            used_re    = 1'b1;
            used_rword = cur_ext[IW-1:bat_pkg::USED_BW];
            state_nxt  = S_FREE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          prev_nxt = {1'b0, cur_r};
          if (enext_q_r >= PTR_LIM) begin
            go_miss = 1'b1;
          end else begin
            ent_re    = 1'b1;
            ent_raddr = enext_q_r[EW-1:0];
            cur_nxt   = enext_q_r[EW-1:0];
          end
        end
      end

      S_FREE: begin
        used_we    = 1'b1;
        used_wword = cur_ext[IW-1:bat_pkg::USED_BW];
        used_wdata = used_rdata &
                     ~(bat_pkg::USED_W'(1) << cur_ext[bat_pkg::USED_BW-1:0]);
        state_nxt  = S_DONE;
      end

      S_SCAN: begin
        if (used_free_any) begin
          used_we     = 1'b1;
          used_wword  = word_r;
          used_wdata  = used_rdata | (bat_pkg::USED_W'(1) << used_free_bit);
          eaddr_we    = 1'b1;
          eaddr_waddr = fnd_ext[EW-1:0];
          enext_we    = 1'b1;
          enext_waddr = fnd_ext[EW-1:0];
          enext_wdata = NIL;
          fidx_nxt    = fnd_ext[EW-1:0];
          state_nxt   = S_LINK;
        end else if (word_r == LAST_WD) begin
          rstat_nxt = bat_pkg::ST_FULL;
          rpres_nxt = 1'b0;
          rhdl_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          word_nxt   = word_r + 1'b1;
          used_re    = 1'b1;
          used_rword = word_r + 1'b1;
        end
      end

      S_LINK: begin
        // append new entry at the chain tail
        if (prev_none) begin
          head_we    = 1'b1;
          head_wdata = {1'b0, fidx_r};
        end else begin
          enext_we    = 1'b1;
          enext_wdata = {1'b0, fidx_r};
        end
        rstat_nxt = bat_pkg::ST_OK;
        rpres_nxt = 1'b0;
        rhdl_nxt  = HW'(fidx_r);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // chain exhausted: insert goes on to allocate, others report a miss
    if (go_miss) begin
      if (mode_r == bat_pkg::MODE_INSERT) begin
        word_nxt   = '0;
        used_re    = 1'b1;
        used_rword = '0;
        state_nxt  = S_SCAN;
      end else begin
        rstat_nxt = bat_pkg::ST_NOT_FOUND;
        rpres_nxt = 1'b0;
        rhdl_nxt  = '0;
        state_nxt = S_DONE;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ostat_nxt  = ostat_r;
    opres_nxt  = opres_r;
    ohdl_nxt   = ohdl_r;
    if ((state_r == S_DONE) && (!ovalid_r || out_ch.ready)) begin
      ovalid_nxt = 1'b1;
      ostat_nxt  = rstat_r;
      opres_nxt  = rpres_r;
      ohdl_nxt   = rhdl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    baddr_r  <= baddr_nxt;
    bucket_r <= bucket_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    word_r   <= word_nxt;
    fidx_r   <= fidx_nxt;
    rstat_r  <= rstat_nxt;
    rpres_r  <= rpres_nxt;
    rhdl_r   <= rhdl_nxt;
    ostat_r  <= ostat_nxt;
    opres_r  <= opres_nxt;
    ohdl_r   <= ohdl_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = ovalid_r;
  assign out_ch.status          = ostat_r;
  assign out_ch.already_present = opres_r;
  assign out_ch.entry_handle    = ohdl_r;

endmodule
